// ===== hdl/i2c_master_register_access_defines.svh =====
// Assertion macros for the I2C master register access RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH
`define I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2CM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("i2cm same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define I2CM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2cm next-cycle check failed");

`endif

// ===== hdl/i2cm_pkg.sv =====
// Shared types and constants for the I2C master register access block.
// No dependencies; imported by the engine and the top level.
package i2cm_pkg;

  // Operation codes carried by an input item.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_REJECT  = 2'd2
  } status_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEV_ADDR    = 2'd0;
  localparam logic [1:0] CFG_HALF_PERIOD = 2'd1;
  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd2;

  // Configuration reset values.
  localparam logic [6:0]  DEV_ADDR_RST    = 7'd0;
  localparam logic [7:0]  HALF_PERIOD_RST = 8'd6;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd1000;

  // Which byte of the transaction is on the bus.
  localparam logic [2:0] STG_ADDR  = 3'd0;
  localparam logic [2:0] STG_REG   = 3'd1;
  localparam logic [2:0] STG_DATA  = 3'd2;
  localparam logic [2:0] STG_RADDR = 3'd3;
  localparam logic [2:0] STG_RDATA = 3'd4;

  // Bus sequencer phases, one-hot.
  typedef enum logic [21:0] {
    PH_IDLE  = 22'h000001,
    PH_ST1   = 22'h000002,
    PH_ST2   = 22'h000004,
    PH_ST3   = 22'h000008,
    PH_WPRE  = 22'h000010,
    PH_WLO   = 22'h000020,
    PH_WHI   = 22'h000040,
    PH_ALO   = 22'h000080,
    PH_AHI   = 22'h000100,
    PH_APOLL = 22'h000200,
    PH_ATAIL = 22'h000400,
    PH_RPRE  = 22'h000800,
    PH_RLO   = 22'h001000,
    PH_RHI1  = 22'h002000,
    PH_RHI2  = 22'h004000,
    PH_NLO   = 22'h008000,
    PH_NHI   = 22'h010000,
    PH_NLO2  = 22'h020000,
    PH_NREL  = 22'h040000,
    PH_SP1   = 22'h080000,
    PH_SP2   = 22'h100000,
    PH_SP3   = 22'h200000
  } phase_e;

  // One input item.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_sample;
  } item_t;

  // One result item.
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_data;
  } result_t;

  // Configuration write request.
  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_req_t;

endpackage

// ===== hdl/i2c_master_register_access.sv =====
// Top level of the I2C master register access block: input register, output
// register and handshakes around i2cm_engine. Depends on i2cm_pkg.
//
// Usage: the input channel (in_valid_i, in_stall_o, in_data_i) carries one item
// per request: a time tick with the sampled SDA level, a register write request
// or a register read request. Each accepted item gives exactly one result on the
// output channel (out_valid_o, out_stall_i, out_data_o) with the SCL and SDA
// levels to drive, busy, done, status and the read byte.
// An accepted item is held in the input register, and its result is then loaded
// into the output register; a stalled receiver can hold the item in between.
// An item can be accepted every cycle while in_stall_o is low.
// A request that arrives during a transaction is answered with the reject status.
// The configuration channel (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i)
// is always ready; write it only while no item is in flight.
// Reset returns the sequencer to idle with both lines released and loads the
// default address, half period and ACK timeout.
// When the receiver stalls, the result stays in the output register and the
// input register still holds one more item; after that in_stall_o is raised.

module i2c_master_register_access (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  i2cm_pkg::item_t    in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output i2cm_pkg::result_t  out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import i2cm_pkg::*;

  logic     in_valid_q;
  item_t    in_item_q;
  logic     out_valid_q;
  result_t  out_res_q;
  result_t  res;
  logic     step;
  logic     in_take;
  cfg_req_t cfg_req;

  // The item in the input register moves on when the output register is free.
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  assign cfg_ready_o   = 1'b1;
  assign cfg_req.index = cfg_index_i;
  assign cfg_req.data  = cfg_data_i;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take || step) begin
      in_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_data_i;
    end
  end

  i2cm_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_valid_i && cfg_ready_o),
    .cfg_req_i (cfg_req),
    .step_i    (step),
    .item_i    (in_item_q),
    .res_o     (res)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= step || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_res_q;

endmodule

// ===== hdl/i2cm_engine.sv =====
// Bus sequencer of the I2C master: configuration registers, transaction state
// and the single-pass next-state logic. Depends on i2cm_pkg and the defines header.
`include "i2c_master_register_access_defines.svh"

module i2cm_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  i2cm_pkg::cfg_req_t cfg_req_i,
  input  logic               step_i,
  input  i2cm_pkg::item_t    item_i,
  output i2cm_pkg::result_t  res_o
);
  import i2cm_pkg::*;

  // Configuration registers.
  logic [6:0]  dev_q;
  logic [7:0]  half_q;
  logic [15:0] tmo_q;

  // Transaction state.
  phase_e      phase_q, phase_d;
  logic [7:0]  ticks_q, ticks_d;
  logic [2:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [16:0] ackcnt_q, ackcnt_d;
  logic        is_read_q, is_read_d;
  logic [2:0]  stage_q, stage_d;
  logic [7:0]  reg_q, reg_d;
  logic [7:0]  wdata_q, wdata_d;
  logic [7:0]  cap_q, cap_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        tout_q, tout_d;

  logic [7:0]  len_full;
  logic [7:0]  len_half;
  logic [16:0] ackcnt_inc;
  logic        done;
  status_e     status;
  logic [7:0]  rdata;

  // Byte that a given transaction stage shifts out.
  function automatic logic [7:0] byte_for(input logic [2:0] stg, input logic [6:0] dev,
                                          input logic [7:0] ra, input logic [7:0] wd);
    logic [7:0] b;
    case (stg)
      STG_ADDR: b = {dev, 1'b0};
      STG_REG:  b = ra;
      STG_DATA: b = wd;
      default:  b = {dev, 1'b1};
    endcase
    return b;
  endfunction

  // Configuration writes; an unknown index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q  <= DEV_ADDR_RST;
      half_q <= HALF_PERIOD_RST;
      tmo_q  <= ACK_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_req_i.index)
        CFG_DEV_ADDR:    dev_q  <= cfg_req_i.data[6:0];
        CFG_HALF_PERIOD: half_q <= cfg_req_i.data[7:0];
        CFG_ACK_TIMEOUT: tmo_q  <= cfg_req_i.data;
        default: ;
      endcase
    end
  end

  // Phase lengths; a phase that works out to zero ticks lasts one.
  assign len_full   = (half_q == 8'd0) ? 8'd1 : half_q;
  assign len_half   = (half_q[7:1] == 7'd0) ? 8'd1 : {1'b0, half_q[7:1]};
  assign ackcnt_inc = ackcnt_q + 17'd1;

  // Next state and result for the item in the input register.
  always_comb begin
    phase_d   = phase_q;
    ticks_d   = ticks_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    ackcnt_d  = ackcnt_q;
    is_read_d = is_read_q;
    stage_d   = stage_q;
    reg_d     = reg_q;
    wdata_d   = wdata_q;
    cap_d     = cap_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    tout_d    = tout_q;
    done      = 1'b0;
    status    = ST_OK;
    rdata     = 8'd0;

    if (step_i) begin
      case (item_i.op)
        OP_TICK: begin
          if (phase_q == PH_IDLE) begin
            // Nothing to advance.
          end else if (phase_q == PH_APOLL) begin
            // ACK poll: a low sample ends it, too many high samples time out.
            if (!item_i.sda_sample) begin
              phase_d = PH_ATAIL;
              ticks_d = len_half;
            end else begin
              ackcnt_d = ackcnt_inc;
              if (ackcnt_inc >= {1'b0, tmo_q}) begin
                tout_d  = 1'b1;
                phase_d = PH_ATAIL;
                ticks_d = len_half;
              end
            end
          end else if (ticks_q > 8'd1) begin
            ticks_d = ticks_q - 8'd1;
          end else begin
            case (phase_q)
              PH_ST1: begin
                sda_d = 1'b0; phase_d = PH_ST2; ticks_d = len_full;
              end
              PH_ST2: begin
                scl_d = 1'b0; phase_d = PH_ST3; ticks_d = len_full;
              end
              PH_ST3: begin
                shift_d = byte_for(stage_q, dev_q, reg_q, wdata_q);
                phase_d = PH_WPRE; ticks_d = len_full;
              end
              PH_WPRE: begin
                bit_d = 3'd7; scl_d = 1'b0; sda_d = shift_q[7];
                phase_d = PH_WLO; ticks_d = len_full;
              end
              PH_WLO: begin
                scl_d = 1'b1; phase_d = PH_WHI; ticks_d = len_full;
              end
              PH_WHI: begin
                scl_d = 1'b0;
                if (bit_q == 3'd0) begin
                  sda_d = 1'b1; phase_d = PH_ALO;
                end else begin
                  bit_d = bit_q - 3'd1;
                  sda_d = shift_q[bit_q - 3'd1];
                  phase_d = PH_WLO;
                end
                ticks_d = len_full;
              end
              PH_ALO: begin
                scl_d = 1'b1; phase_d = PH_AHI; ticks_d = len_half;
              end
              PH_AHI: begin
                ackcnt_d = 17'd0; phase_d = PH_APOLL; ticks_d = 8'd0;
              end
              PH_ATAIL: begin
                // The ACK is over: pick the next byte, a repeated start or the stop.
                scl_d = 1'b0;
                if (tout_q) begin
                  sda_d = 1'b0; phase_d = PH_SP1; ticks_d = len_full;
                end else begin
                  case (stage_q)
                    STG_ADDR: begin
                      stage_d = STG_REG;
                      shift_d = byte_for(STG_REG, dev_q, reg_q, wdata_q);
                      phase_d = PH_WPRE; ticks_d = len_full;
                    end
                    STG_REG: begin
                      if (is_read_q) begin
                        stage_d = STG_RADDR; sda_d = 1'b1; scl_d = 1'b1;
                        phase_d = PH_ST1;
                      end else begin
                        stage_d = STG_DATA;
                        shift_d = byte_for(STG_DATA, dev_q, reg_q, wdata_q);
                        phase_d = PH_WPRE;
                      end
                      ticks_d = len_full;
                    end
                    STG_RADDR: begin
                      stage_d = STG_RDATA; sda_d = 1'b1;
                      phase_d = PH_RPRE; ticks_d = len_full;
                    end
                    default: begin
                      sda_d = 1'b0; phase_d = PH_SP1; ticks_d = len_full;
                    end
                  endcase
                end
              end
              PH_RPRE: begin
                bit_d = 3'd7; cap_d = 8'd0; scl_d = 1'b0;
                phase_d = PH_RLO; ticks_d = len_full;
              end
              PH_RLO: begin
                scl_d = 1'b1; phase_d = PH_RHI1; ticks_d = len_half;
              end
              PH_RHI1: begin
                cap_d = {cap_q[6:0], item_i.sda_sample};
                phase_d = PH_RHI2; ticks_d = len_half;
              end
              PH_RHI2: begin
                scl_d = 1'b0;
                if (bit_q == 3'd0) begin
                  sda_d = 1'b1; phase_d = PH_NLO;
                end else begin
                  bit_d = bit_q - 3'd1; phase_d = PH_RLO;
                end
                ticks_d = len_full;
              end
              PH_NLO: begin
                scl_d = 1'b1; phase_d = PH_NHI; ticks_d = len_full;
              end
              PH_NHI: begin
                scl_d = 1'b0; phase_d = PH_NLO2; ticks_d = len_full;
              end
              PH_NLO2: begin
                sda_d = 1'b1; phase_d = PH_NREL; ticks_d = len_full;
              end
              PH_NREL: begin
                sda_d = 1'b0; phase_d = PH_SP1; ticks_d = len_full;
              end
              PH_SP1: begin
                scl_d = 1'b1; phase_d = PH_SP2; ticks_d = len_full;
              end
              PH_SP2: begin
                sda_d = 1'b1; phase_d = PH_SP3; ticks_d = len_full;
              end
              PH_SP3: begin
                // Stop complete: report the outcome.
                phase_d = PH_IDLE; ticks_d = 8'd0; done = 1'b1;
                status  = tout_q ? ST_TIMEOUT : ST_OK;
                rdata   = (is_read_q && !tout_q) ? cap_q : 8'd0;
              end
              default: begin
                phase_d = PH_IDLE; ticks_d = 8'd0;
              end
            endcase
          end
        end
        OP_WRITE, OP_READ: begin
          // A request starts a transaction only from idle.
          if (phase_q != PH_IDLE) begin
            status = ST_REJECT;
          end else begin
            is_read_d = (item_i.op == OP_READ);
            reg_d     = item_i.reg_addr;
            wdata_d   = item_i.write_data;
            stage_d   = STG_ADDR;
            tout_d    = 1'b0;
            cap_d     = 8'd0;
            ackcnt_d  = 17'd0;
            sda_d     = 1'b1;
            scl_d     = 1'b1;
            phase_d   = PH_ST1;
            ticks_d   = len_full;
          end
        end
        default: ;
      endcase
    end

    res_o.scl_level = scl_d;
    res_o.sda_level = sda_d;
    res_o.busy_res  = (phase_d != PH_IDLE);
    res_o.done_res  = done;
    res_o.status    = status;
    res_o.read_data = rdata;
  end

  // Transaction state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      ticks_q   <= 8'd0;
      bit_q     <= 3'd0;
      shift_q   <= 8'd0;
      ackcnt_q  <= 17'd0;
      is_read_q <= 1'b0;
      stage_q   <= STG_ADDR;
      reg_q     <= 8'd0;
      wdata_q   <= 8'd0;
      cap_q     <= 8'd0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      tout_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      ticks_q   <= ticks_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      ackcnt_q  <= ackcnt_d;
      is_read_q <= is_read_d;
      stage_q   <= stage_d;
      reg_q     <= reg_d;
      wdata_q   <= wdata_d;
      cap_q     <= cap_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      tout_q    <= tout_d;
    end
  end

  // An idle bus has both lines released.
  `I2CM_ASSERT_IMPL(a_idle_lines_released, phase_q == PH_IDLE, scl_q && sda_q)
  // Every counted phase has at least one tick left.
  `I2CM_ASSERT_IMPL(a_counted_phase_nonzero,
                    phase_q != PH_IDLE && phase_q != PH_APOLL, ticks_q != 8'd0)
  // A request or no-op during a transaction leaves the lines untouched.
  `I2CM_ASSERT_NEXT(a_busy_nontick_holds,
                    step_i && item_i.op != OP_TICK && phase_q != PH_IDLE,
                    $stable(scl_q) && $stable(sda_q) && $stable(phase_q))
  // A finished transaction returns the sequencer to idle.
  `I2CM_ASSERT_NEXT(a_done_goes_idle, step_i && done, phase_q == PH_IDLE)

endmodule
